// ===== rtl/affine_matrix_decompose_euler_core_macros.svh =====
// Assertion macros for the affine decompose core.
// Used by the top level only; no other dependencies.
`ifndef AFFINE_MATRIX_DECOMPOSE_EULER_CORE_MACROS_SVH
`define AFFINE_MATRIX_DECOMPOSE_EULER_CORE_MACROS_SVH

// same-cycle implication
`define AMDE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("amde assertion failed");

// next-cycle implication
`define AMDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("amde assertion failed");

`endif

// ===== rtl/amde_pkg.sv =====
// Shared widths, constants and the CORDIC angle table for the affine decompose core.
// No dependencies.
`timescale 1ns / 1ps
package amde_pkg;

  localparam int unsigned EW           = 32;  // Q16.16 entry width
  localparam int unsigned FRAC         = 30;  // Q2.30 fraction bits
  localparam int unsigned QW           = 32;  // normalized entry width
  localparam int unsigned ROT_W        = 19;  // Q3.16 angle width
  localparam int unsigned CW           = 34;  // CORDIC datapath width
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned ANG_SH       = 14;  // Q2.30 -> Q3.16
  localparam int unsigned SQ_W         = 64;  // column sum of squares
  localparam int unsigned H_W          = 62;  // rot_y hypotenuse radicand
  localparam int unsigned IN_DATA_W    = 384;
  localparam int unsigned OUT_DATA_W   = 256;

  localparam int HALF_PI_Q30 = 1686629713;
  localparam int ROT_LIMIT   = 205887;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

endpackage

// ===== rtl/amde_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, round to nearest (ties up),
// saturated. Carries a sideband word alongside. Depends on nothing.
`timescale 1ns / 1ps
module amde_sqrt #(
  parameter int unsigned IN_W = 64,
  parameter int unsigned SB_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SB_W-1:0]   side_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [SB_W-1:0]   side_o
);
  localparam int unsigned RW = IN_W / 2;

  logic [IN_W-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SB_W-1:0] side_q [RW];
  logic [RW-1:0]   vld_q;

  logic [IN_W-1:0] rem_c  [RW+1];
  logic [RW-1:0]   root_c [RW+1];
  logic [SB_W-1:0] side_c [RW+1];
  logic [RW:0]     vld_c;

  logic [IN_W-1:0] rem_d  [RW];
  logic [RW-1:0]   root_d [RW];
  logic [IN_W:0]   trial;

  logic            inc;
  logic [RW:0]     sum;
  logic [RW-1:0]   rnd;
  logic [RW-1:0]   root_out_q;
  logic [SB_W-1:0] side_out_q;
  logic            vld_out_q;

  always_comb begin
    rem_c[0]  = rad_i;
    root_c[0] = '0;
    side_c[0] = side_i;
    vld_c[0]  = valid_i;
    for (int s = 0; s < RW; s++) begin
      rem_c[s+1]  = rem_q[s];
      root_c[s+1] = root_q[s];
      side_c[s+1] = side_q[s];
      vld_c[s+1]  = vld_q[s];
    end
  end

  // stage s settles root bit RW-1-s: test (r + 2^j)^2 <= v against remainder
  always_comb begin
    trial = '0;
    for (int s = 0; s < RW; s++) begin
      trial = ((IN_W+1)'(root_c[s]) << (RW - s)) | ((IN_W+1)'(1) << (2 * (RW - 1 - s)));
      if ({1'b0, rem_c[s]} >= trial) begin
        rem_d[s]  = rem_c[s] - trial[IN_W-1:0];
        root_d[s] = root_c[s] | (RW'(1) << (RW - 1 - s));
      end else begin
        rem_d[s]  = rem_c[s];
        root_d[s] = root_c[s];
      end
    end
  end

  always_comb begin
    inc = rem_c[RW] > IN_W'(root_c[RW]);
    sum = {1'b0, root_c[RW]} + (RW+1)'(inc);
    rnd = sum[RW] ? '1 : sum[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= vld_c[RW-1:0];
      vld_out_q <= vld_c[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < RW; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        side_q[s] <= side_c[s];
      end
      root_out_q <= rnd;
      side_out_q <= side_c[RW];
    end
  end

  assign valid_o = vld_out_q;
  assign root_o  = root_out_q;
  assign side_o  = side_out_q;

endmodule

// ===== rtl/amde_div.sv =====
// Pipelined restoring divider: num * 2^30 / den, round half away from zero.
// One quotient bit per stage. Depends on amde_pkg.
`timescale 1ns / 1ps
module amde_div #(
  parameter int unsigned SB_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [amde_pkg::EW-1:0]    num_i,
  input  logic        [amde_pkg::EW-1:0]    den_i,
  input  logic        [SB_W-1:0]            side_i,
  output logic                              valid_o,
  output logic signed [amde_pkg::QW-1:0]    quo_o,
  output logic        [SB_W-1:0]            side_o
);
  localparam int unsigned EW = amde_pkg::EW;
  localparam int unsigned NW = amde_pkg::EW + amde_pkg::FRAC;
  localparam int unsigned QB = amde_pkg::FRAC + 1;
  localparam int unsigned QW = amde_pkg::QW;

  logic [NW-1:0]   r_q    [QB];
  logic [QB-1:0]   q_q    [QB];
  logic [EW-1:0]   d_q    [QB];
  logic [QB-1:0]   neg_q;
  logic [SB_W-1:0] side_q [QB];
  logic [QB-1:0]   vld_q;

  logic [NW-1:0]   r_c    [QB+1];
  logic [QB-1:0]   q_c    [QB+1];
  logic [EW-1:0]   d_c    [QB+1];
  logic [QB:0]     neg_c;
  logic [SB_W-1:0] side_c [QB+1];
  logic [QB:0]     vld_c;

  logic [NW-1:0]   r_d [QB];
  logic [QB-1:0]   q_d [QB];
  logic [NW:0]     sh;
  logic [EW-1:0]   mag;

  logic                 inc;
  logic [QB-1:0]        qr;
  logic signed [QW-1:0] res;
  logic signed [QW-1:0] quo_q;
  logic [SB_W-1:0]      side_out_q;
  logic                 vld_out_q;

  always_comb begin
    mag       = num_i[EW-1] ? EW'(-num_i) : EW'(num_i);
    r_c[0]    = {mag, amde_pkg::FRAC'(0)};
    q_c[0]    = '0;
    d_c[0]    = den_i;
    neg_c[0]  = num_i[EW-1];
    side_c[0] = side_i;
    vld_c[0]  = valid_i;
    for (int s = 0; s < QB; s++) begin
      r_c[s+1]    = r_q[s];
      q_c[s+1]    = q_q[s];
      d_c[s+1]    = d_q[s];
      neg_c[s+1]  = neg_q[s];
      side_c[s+1] = side_q[s];
      vld_c[s+1]  = vld_q[s];
    end
  end

  always_comb begin
    sh = '0;
    for (int s = 0; s < QB; s++) begin
      sh = (NW+1)'(d_c[s]) << (QB - 1 - s);
      if ({1'b0, r_c[s]} >= sh) begin
        r_d[s] = r_c[s] - sh[NW-1:0];
        q_d[s] = q_c[s] | (QB'(1) << (QB - 1 - s));
      end else begin
        r_d[s] = r_c[s];
        q_d[s] = q_c[s];
      end
    end
  end

  // round up when twice the remainder reaches the divisor
  always_comb begin
    inc = ((NW+1)'(r_c[QB]) << 1) >= (NW+1)'(d_c[QB]);
    qr  = q_c[QB] + QB'(inc);
    res = neg_c[QB] ? -QW'(qr) : QW'(qr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= vld_c[QB-1:0];
      vld_out_q <= vld_c[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QB; s++) begin
        r_q[s]    <= r_d[s];
        q_q[s]    <= q_d[s];
        d_q[s]    <= d_c[s];
        side_q[s] <= side_c[s];
      end
      neg_q      <= neg_c[QB-1:0];
      quo_q      <= res;
      side_out_q <= side_c[QB];
    end
  end

  assign valid_o = vld_out_q;
  assign quo_o   = quo_q;
  assign side_o  = side_out_q;

endmodule

// ===== rtl/amde_cordic.sv =====
// Pipelined CORDIC atan2 in vectoring mode, one step per stage, Q2.30 angle
// rounded to a clamped Q3.16 result. Depends on amde_pkg.
`timescale 1ns / 1ps
module amde_cordic #(
  parameter int unsigned SB_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [amde_pkg::QW-1:0]     y_i,
  input  logic signed [amde_pkg::QW-1:0]     x_i,
  input  logic        [SB_W-1:0]             side_i,
  output logic                               valid_o,
  output logic signed [amde_pkg::ROT_W-1:0]  ang_o,
  output logic        [SB_W-1:0]             side_o
);
  localparam int unsigned CW    = amde_pkg::CW;
  localparam int unsigned NS    = amde_pkg::CORDIC_STEPS;
  localparam int unsigned SH    = amde_pkg::ANG_SH;
  localparam int unsigned ROT_W = amde_pkg::ROT_W;

  logic signed [CW-1:0] x_q [NS];
  logic signed [CW-1:0] y_q [NS];
  logic signed [CW-1:0] z_q [NS];
  logic [NS-1:0]        zf_q;
  logic [SB_W-1:0]      side_q [NS];
  logic [NS-1:0]        vld_q;

  logic signed [CW-1:0] x_c [NS+1];
  logic signed [CW-1:0] y_c [NS+1];
  logic signed [CW-1:0] z_c [NS+1];
  logic [NS:0]          zf_c;
  logic [SB_W-1:0]      side_c [NS+1];
  logic [NS:0]          vld_c;

  logic signed [CW-1:0] x_d [NS];
  logic signed [CW-1:0] y_d [NS];
  logic signed [CW-1:0] z_d [NS];
  logic signed [CW-1:0] xe, ye, xs, ys;

  logic [CW-1:0]              mag;
  logic [CW-1:0]              rsum;
  logic [CW-SH-1:0]           qt;
  logic [ROT_W-1:0]           qc;
  logic signed [ROT_W-1:0]    ang;
  logic signed [ROT_W-1:0]    ang_q;
  logic [SB_W-1:0]            side_out_q;
  logic                       vld_out_q;

  // quarter-turn pre-rotation brings x into the right half plane
  always_comb begin
    xe = CW'(x_i);
    ye = CW'(y_i);
    if (xe < 0) begin
      if (ye >= 0) begin
        x_c[0] = ye;
        y_c[0] = -xe;
        z_c[0] = CW'(amde_pkg::HALF_PI_Q30);
      end else begin
        x_c[0] = -ye;
        y_c[0] = xe;
        z_c[0] = -CW'(amde_pkg::HALF_PI_Q30);
      end
    end else begin
      x_c[0] = xe;
      y_c[0] = ye;
      z_c[0] = '0;
    end
    zf_c[0]   = (x_i == '0) && (y_i == '0);
    side_c[0] = side_i;
    vld_c[0]  = valid_i;
    for (int s = 0; s < NS; s++) begin
      x_c[s+1]    = x_q[s];
      y_c[s+1]    = y_q[s];
      z_c[s+1]    = z_q[s];
      zf_c[s+1]   = zf_q[s];
      side_c[s+1] = side_q[s];
      vld_c[s+1]  = vld_q[s];
    end
  end

  always_comb begin
    xs = '0;
    ys = '0;
    for (int s = 0; s < NS; s++) begin
      xs = x_c[s] >>> s;
      ys = y_c[s] >>> s;
      if (y_c[s] >= 0) begin
        x_d[s] = x_c[s] + ys;
        y_d[s] = y_c[s] - xs;
        z_d[s] = z_c[s] + CW'(amde_pkg::ATAN_TAB[s]);
      end else begin
        x_d[s] = x_c[s] - ys;
        y_d[s] = y_c[s] + xs;
        z_d[s] = z_c[s] - CW'(amde_pkg::ATAN_TAB[s]);
      end
    end
  end

  always_comb begin
    mag  = z_c[NS][CW-1] ? CW'(-z_c[NS]) : CW'(z_c[NS]);
    rsum = mag + (CW'(1) << (SH - 1));
    qt   = rsum[CW-1:SH];
    qc   = (qt > (CW-SH)'(amde_pkg::ROT_LIMIT)) ? ROT_W'(amde_pkg::ROT_LIMIT)
                                                : qt[ROT_W-1:0];
    if (zf_c[NS]) begin
      ang = '0;
    end else begin
      ang = z_c[NS][CW-1] ? -signed'(qc) : signed'(qc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= vld_c[NS-1:0];
      vld_out_q <= vld_c[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        x_q[s]    <= x_d[s];
        y_q[s]    <= y_d[s];
        z_q[s]    <= z_d[s];
        side_q[s] <= side_c[s];
      end
      zf_q       <= zf_c[NS-1:0];
      ang_q      <= ang;
      side_out_q <= side_c[NS];
    end
  end

  assign valid_o = vld_out_q;
  assign ang_o   = ang_q;
  assign side_o  = side_out_q;

endmodule

// ===== rtl/affine_matrix_decompose_euler_core.sv =====
// Affine 4x4 decomposition: scale, XYZ Euler rotation and translation.
// Throughput: one matrix per cycle while the 2-word output buffer is not full; every stage
// (squares, roots, 31-stage dividers, 30-step CORDIC) is fully pipelined. When the buffer
// holds two words, the whole pipeline stalls and s_axis_tready_o is low.
// Reset: asynchronous active low, clears valid bits and the output buffer.
// Uses amde_pkg, amde_sqrt, amde_div, amde_cordic and the assertion macro header.
`timescale 1ns / 1ps
`include "affine_matrix_decompose_euler_core_macros.svh"
module affine_matrix_decompose_euler_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z,
  // col3_x, col3_y, col3_z (32 bits each)
  input  logic [amde_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // trans_x, trans_y, trans_z (32), rot_x, rot_y, rot_z (19),
  // scale_x, scale_y, scale_z (32), zero pad (7)
  output logic [amde_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // zero_scale
  output logic                               m_axis_tuser_o
);
  localparam int unsigned EW    = amde_pkg::EW;
  localparam int unsigned ROT_W = amde_pkg::ROT_W;

  typedef struct packed {
    logic signed [EW-1:0] e0, e1, e2, e5, e8;
    logic signed [EW-1:0] tx, ty, tz;
  } sb_b_t;

  typedef struct packed {
    logic signed [EW-1:0] tx, ty, tz;
    logic [EW-1:0]        sc0, sc1, sc2;
    logic                 zero;
  } sb_d_t;

  typedef struct packed {
    logic signed [amde_pkg::QW-1:0] n00, n01, n02, n12, n22;
    sb_d_t                          d;
  } sb_c_t;

  typedef struct packed {
    logic signed [EW-1:0]    tx, ty, tz;
    logic signed [ROT_W-1:0] rx, ry, rz;
    logic [EW-1:0]           sc0, sc1, sc2;
    logic                    zero;
  } res_t;

  logic en;
  logic [1:0] cnt_q;

  // stage A: squares
  logic signed [EW-1:0] ein [12];
  logic signed [63:0]   prod [9];
  logic [62:0]          sq_q [9];
  logic                 va_q;
  sb_b_t                sba_q;

  // stage B: column sums
  logic [amde_pkg::SQ_W-1:0] ssum_q [3];
  logic                      vb_q;
  sb_b_t                     sbb_q;

  logic [2:0]    vs;
  logic [EW-1:0] sc [3];
  sb_b_t         sbs;
  sb_d_t         sbd_in;

  logic [4:0]                     vd;
  logic signed [amde_pkg::QW-1:0] nq [5];
  sb_d_t                          sbd;

  // stage C: hypotenuse radicand
  logic signed [63:0]       hp12, hp22;
  logic [63:0]              hsum;
  logic [amde_pkg::H_W-1:0] hsum_q;
  logic                     vc_q;
  sb_c_t                    sbc_q;

  logic                         vh;
  logic [amde_pkg::H_W/2-1:0]   hroot;
  sb_c_t                        sbh;

  logic [2:0]              vr;
  logic signed [ROT_W-1:0] angx, angy, angz;
  sb_d_t                   sbr;

  res_t res;
  res_t fifo_q [2];
  logic wr_q, rd_q;
  logic push, pop;

  assign en              = (cnt_q != 2'd2);
  assign s_axis_tready_o = en;

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      ein[k] = signed'(s_axis_tdata_i[k*EW +: EW]);
    end
    for (int k = 0; k < 9; k++) begin
      prod[k] = ein[k] * ein[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid_i;
      vb_q <= va_q;
      vc_q <= vd[0];
    end
  end

  always_comb begin
    hp12 = nq[3] * nq[3];
    hp22 = nq[4] * nq[4];
    hsum = 64'(hp12) + 64'(hp22);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        sq_q[k] <= prod[k][62:0];
      end
      sba_q <= '{e0: ein[0], e1: ein[1], e2: ein[2], e5: ein[5], e8: ein[8],
                 tx: ein[9], ty: ein[10], tz: ein[11]};
      for (int c = 0; c < 3; c++) begin
        ssum_q[c] <= 64'(sq_q[3*c]) + 64'(sq_q[3*c+1]) + 64'(sq_q[3*c+2]);
      end
      sbb_q  <= sba_q;
      hsum_q <= hsum[amde_pkg::H_W-1:0];
      sbc_q  <= '{n00: nq[0], n01: nq[1], n02: nq[2], n12: nq[3], n22: nq[4], d: sbd};
    end
  end

  amde_sqrt #(.IN_W(amde_pkg::SQ_W), .SB_W($bits(sb_b_t))) u_sqrt_s0 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q), .rad_i(ssum_q[0]), .side_i(sbb_q),
    .valid_o(vs[0]), .root_o(sc[0]), .side_o(sbs)
  );
  amde_sqrt #(.IN_W(amde_pkg::SQ_W), .SB_W(1)) u_sqrt_s1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q), .rad_i(ssum_q[1]), .side_i(1'b0),
    .valid_o(vs[1]), .root_o(sc[1]), .side_o()
  );
  amde_sqrt #(.IN_W(amde_pkg::SQ_W), .SB_W(1)) u_sqrt_s2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q), .rad_i(ssum_q[2]), .side_i(1'b0),
    .valid_o(vs[2]), .root_o(sc[2]), .side_o()
  );

  assign sbd_in = '{tx: sbs.tx, ty: sbs.ty, tz: sbs.tz, sc0: sc[0], sc1: sc[1],
                    sc2: sc[2],
                    zero: (sc[0] == '0) || (sc[1] == '0) || (sc[2] == '0)};

  amde_div #(.SB_W($bits(sb_d_t))) u_div_00 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs[0]), .num_i(sbs.e0), .den_i(sc[0]),
    .side_i(sbd_in), .valid_o(vd[0]), .quo_o(nq[0]), .side_o(sbd)
  );
  amde_div #(.SB_W(1)) u_div_01 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs[0]), .num_i(sbs.e1), .den_i(sc[0]),
    .side_i(1'b0), .valid_o(vd[1]), .quo_o(nq[1]), .side_o()
  );
  amde_div #(.SB_W(1)) u_div_02 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs[0]), .num_i(sbs.e2), .den_i(sc[0]),
    .side_i(1'b0), .valid_o(vd[2]), .quo_o(nq[2]), .side_o()
  );
  amde_div #(.SB_W(1)) u_div_12 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs[0]), .num_i(sbs.e5), .den_i(sc[1]),
    .side_i(1'b0), .valid_o(vd[3]), .quo_o(nq[3]), .side_o()
  );
  amde_div #(.SB_W(1)) u_div_22 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs[0]), .num_i(sbs.e8), .den_i(sc[2]),
    .side_i(1'b0), .valid_o(vd[4]), .quo_o(nq[4]), .side_o()
  );

  amde_sqrt #(.IN_W(amde_pkg::H_W), .SB_W($bits(sb_c_t))) u_sqrt_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vc_q), .rad_i(hsum_q), .side_i(sbc_q),
    .valid_o(vh), .root_o(hroot), .side_o(sbh)
  );

  amde_cordic #(.SB_W($bits(sb_d_t))) u_atan_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vh), .y_i(sbh.n12), .x_i(sbh.n22),
    .side_i(sbh.d), .valid_o(vr[0]), .ang_o(angx), .side_o(sbr)
  );
  amde_cordic #(.SB_W(1)) u_atan_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vh), .y_i(-sbh.n02),
    .x_i(signed'({1'b0, hroot})), .side_i(1'b0), .valid_o(vr[1]), .ang_o(angy),
    .side_o()
  );
  amde_cordic #(.SB_W(1)) u_atan_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vh), .y_i(sbh.n01), .x_i(sbh.n00),
    .side_i(1'b0), .valid_o(vr[2]), .ang_o(angz), .side_o()
  );

  // rotations are forced to zero when any column collapses
  always_comb begin
    res.tx   = sbr.tx;
    res.ty   = sbr.ty;
    res.tz   = sbr.tz;
    res.rx   = sbr.zero ? '0 : angx;
    res.ry   = sbr.zero ? '0 : angy;
    res.rz   = sbr.zero ? '0 : angz;
    res.sc0  = sbr.sc0;
    res.sc1  = sbr.sc1;
    res.sc2  = sbr.sc2;
    res.zero = sbr.zero;
  end

  // two-word output buffer
  assign push = vr[0] & en;
  assign pop  = m_axis_tvalid_o & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {7'd0, fifo_q[rd_q].sc2, fifo_q[rd_q].sc1, fifo_q[rd_q].sc0,
                            fifo_q[rd_q].rz, fifo_q[rd_q].ry, fifo_q[rd_q].rx,
                            fifo_q[rd_q].tz, fifo_q[rd_q].ty, fifo_q[rd_q].tx};
  assign m_axis_tuser_o  = fifo_q[rd_q].zero;

  `AMDE_ASSERT_IMPL(a_lanes_aligned, clk_i, rst_ni, 1'b1, (vs == 3'b000 || vs == 3'b111) && (vr == 3'b000 || vr == 3'b111))
  `AMDE_ASSERT_IMPL(a_div_lanes, clk_i, rst_ni, 1'b1, vd == 5'b00000 || vd == 5'b11111)
  `AMDE_ASSERT_IMPL(a_zero_rot, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[152:96] == 57'd0)
  `AMDE_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push, cnt_q != 2'd0)

endmodule
